@@ src/qrct_pkg.sv @@
// Shared types, codes, reset constants and helpers for the QUIC receive credit tracker.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package qrct_pkg;

    // Width of every byte count, stream ID and limit.
    localparam int VALUE_BITS   = 62;
    localparam int PAYLOAD_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [VALUE_BITS-1:0]   value_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;

    // Operation carried by an input word.
    typedef enum logic [1:0] {
        MODE_ARRIVAL = 2'd0,
        MODE_POLL    = 2'd1,
        MODE_STREAM  = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    // Which limit an update advertises.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_BIDI = 2'd1,
        KIND_UNI  = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INIT_DATA_LIMIT   = 3'd0,
        CFG_INIT_BIDI_LIMIT   = 3'd1,
        CFG_INIT_UNI_LIMIT    = 3'd2,
        CFG_DATA_GROW_THRESH  = 3'd3,
        CFG_DATA_GROW_AMOUNT  = 3'd4,
        CFG_STREAM_GROW_THRESH = 3'd5,
        CFG_STREAM_GROW_AMOUNT = 3'd6
    } cfg_index_t;

    // Reset values of the grow settings.
    localparam value_t DATA_GROW_THRESH_RST   = value_t'(16384);
    localparam value_t DATA_GROW_AMOUNT_RST   = value_t'(65536);
    localparam value_t STREAM_GROW_THRESH_RST = value_t'(2);
    localparam value_t STREAM_GROW_AMOUNT_RST = value_t'(10);

    // One result word.
    typedef struct packed {
        logic   accepted;
        logic   update_valid;
        kind_t  update_kind;
        value_t update_limit;
    } result_t;

    // Addition that sticks at the all-ones value.
    function automatic value_t sat_add(input value_t a, input value_t b);
        logic [VALUE_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/qrct_data_credit.sv @@
// Connection byte credit: counts received bytes and raises the data limit on a poll.
// Depends on qrct_pkg.
`default_nettype none

module qrct_data_credit (
    input  wire logic             arrival,
    input  wire qrct_pkg::payload_t payload_size,
    input  wire qrct_pkg::value_t total,
    input  wire qrct_pkg::value_t limit,
    input  wire qrct_pkg::value_t grow_threshold,
    input  wire qrct_pkg::value_t grow_amount,
    output qrct_pkg::value_t      total_next,
    output qrct_pkg::value_t      limit_next,
    output qrct_pkg::result_t     res
);

    qrct_pkg::value_t size_ext;
    qrct_pkg::value_t arrived_total;
    qrct_pkg::value_t remaining;
    qrct_pkg::value_t raised_limit;
    logic             over;
    logic             raise;

    assign size_ext = {{(qrct_pkg::VALUE_BITS - qrct_pkg::PAYLOAD_BITS){1'b0}}, payload_size};

    // Both candidate sums run side by side; the mode picks one.
    assign arrived_total = qrct_pkg::sat_add(total, size_ext);
    assign raised_limit  = qrct_pkg::sat_add(limit, grow_amount);
    assign over          = total > limit;
    assign remaining     = limit - total;
    assign raise         = !over && (remaining <= grow_threshold);

    always_comb
    begin
        res.update_valid = 1'b0;
        res.update_kind  = qrct_pkg::KIND_DATA;
        res.update_limit = '0;
        if (arrival)
        begin
            // Bytes are counted even when they break the limit.
            total_next   = arrived_total;
            limit_next   = limit;
            res.accepted = !(arrived_total > limit);
        end
        else
        begin
            total_next   = total;
            limit_next   = raise ? raised_limit : limit;
            res.accepted = !over;
            if (raise)
            begin
                res.update_valid = 1'b1;
                res.update_limit = raised_limit;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/qrct_stream_credit.sv @@
// Stream count credit: tracks the highest peer stream ID per direction and raises its limit.
// Depends on qrct_pkg.
`default_nettype none

module qrct_stream_credit (
    input  wire qrct_pkg::value_t peer_sid,
    input  wire qrct_pkg::value_t highest_bidi,
    input  wire qrct_pkg::value_t highest_uni,
    input  wire qrct_pkg::value_t limit_bidi,
    input  wire qrct_pkg::value_t limit_uni,
    input  wire qrct_pkg::value_t grow_threshold,
    input  wire qrct_pkg::value_t grow_amount,
    output qrct_pkg::value_t      highest_bidi_next,
    output qrct_pkg::value_t      highest_uni_next,
    output qrct_pkg::value_t      limit_bidi_next,
    output qrct_pkg::value_t      limit_uni_next,
    output qrct_pkg::result_t     res
);

    logic             uni;
    qrct_pkg::value_t highest;
    qrct_pkg::value_t highest_new;
    qrct_pkg::value_t limit;
    qrct_pkg::value_t count;
    qrct_pkg::value_t remaining;
    qrct_pkg::value_t raised_limit;
    logic             over;
    logic             raise;

    // Bit 1 of the ID marks a unidirectional stream.
    assign uni     = peer_sid[1];
    assign highest = uni ? highest_uni : highest_bidi;
    assign limit   = uni ? limit_uni : limit_bidi;

    // The highest ID is recorded whether or not the limit holds.
    assign highest_new  = (peer_sid > highest) ? peer_sid : highest;
    assign count        = highest_new >> 2;
    assign over         = count >= limit;
    assign remaining    = limit - count;
    assign raise        = !over && (remaining <= grow_threshold);
    assign raised_limit = qrct_pkg::sat_add(limit, grow_amount);

    always_comb
    begin
        highest_bidi_next = uni ? highest_bidi : highest_new;
        highest_uni_next  = uni ? highest_new : highest_uni;
        limit_bidi_next   = (!uni && raise) ? raised_limit : limit_bidi;
        limit_uni_next    = (uni && raise) ? raised_limit : limit_uni;

        res.accepted     = !over;
        res.update_valid = raise;
        res.update_kind  = qrct_pkg::KIND_DATA;
        res.update_limit = '0;
        if (raise)
        begin
            res.update_kind  = uni ? qrct_pkg::KIND_UNI : qrct_pkg::KIND_BIDI;
            res.update_limit = raised_limit;
        end
    end

endmodule

`default_nettype wire

@@ src/quic_receive_credit_tracker.sv @@
// Top level of the QUIC receive credit tracker: input register, state, result register.
// Depends on qrct_pkg, qrct_data_credit and qrct_stream_credit.
`default_nettype none

// Channel   | Handshake             | Word
// ----------+-----------------------+--------------------------------------------------
// input     | in_valid / in_ready   | mode, payload_size, peer_sid
// result    | out_valid / out_ready | accepted, update_valid, update_kind, update_limit
// config    | cfg_write_en          | cfg_index, cfg_data (no wait, no read-back)
//
// One word is accepted per cycle while in_ready is high.
// The credit state is read combinationally between the input register and the result
// register and written with it, so consecutive words see each other's updates.
// A stalled result holds its register; the input register still takes one more word.
// Reset clears the counts and IDs, zeroes the limits and loads the default grow settings.

module quic_receive_credit_tracker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            mode,
    input  wire qrct_pkg::payload_t    payload_size,
    input  wire qrct_pkg::value_t      peer_sid,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       accepted,
    output logic                       update_valid,
    output logic [1:0]                 update_kind,
    output qrct_pkg::value_t           update_limit,

    input  wire logic                  cfg_write_en,
    input  wire logic [qrct_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire qrct_pkg::value_t      cfg_data
);

    // Input register.
    logic               in_valid_reg;
    qrct_pkg::mode_t    mode_reg;
    qrct_pkg::payload_t payload_size_reg;
    qrct_pkg::value_t   peer_sid_reg;

    // Result register.
    logic               out_valid_reg;
    qrct_pkg::result_t  res_reg;
    qrct_pkg::result_t  res_next;

    // Settings.
    qrct_pkg::value_t   data_thresh_reg;
    qrct_pkg::value_t   data_amount_reg;
    qrct_pkg::value_t   stream_thresh_reg;
    qrct_pkg::value_t   stream_amount_reg;

    // Credit state.
    qrct_pkg::value_t   total_reg;
    qrct_pkg::value_t   data_limit_reg;
    qrct_pkg::value_t   bidi_limit_reg;
    qrct_pkg::value_t   uni_limit_reg;
    qrct_pkg::value_t   highest_bidi_reg;
    qrct_pkg::value_t   highest_uni_reg;

    qrct_pkg::value_t   total_next;
    qrct_pkg::value_t   data_limit_next;
    qrct_pkg::value_t   bidi_limit_next;
    qrct_pkg::value_t   uni_limit_next;
    qrct_pkg::value_t   highest_bidi_next;
    qrct_pkg::value_t   highest_uni_next;
    qrct_pkg::result_t  data_res;
    qrct_pkg::result_t  stream_res;

    logic               advance;
    logic               fire;

    // The result register frees up when empty or taken; the input word moves then.
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg         <= qrct_pkg::mode_t'(mode);
            payload_size_reg <= payload_size;
            peer_sid_reg     <= peer_sid;
        end
    end

    qrct_data_credit u_data (
        .arrival        (mode_reg == qrct_pkg::MODE_ARRIVAL),
        .payload_size   (payload_size_reg),
        .total          (total_reg),
        .limit          (data_limit_reg),
        .grow_threshold (data_thresh_reg),
        .grow_amount    (data_amount_reg),
        .total_next     (total_next),
        .limit_next     (data_limit_next),
        .res            (data_res)
    );

    qrct_stream_credit u_stream (
        .peer_sid          (peer_sid_reg),
        .highest_bidi      (highest_bidi_reg),
        .highest_uni       (highest_uni_reg),
        .limit_bidi        (bidi_limit_reg),
        .limit_uni         (uni_limit_reg),
        .grow_threshold    (stream_thresh_reg),
        .grow_amount       (stream_amount_reg),
        .highest_bidi_next (highest_bidi_next),
        .highest_uni_next  (highest_uni_next),
        .limit_bidi_next   (bidi_limit_next),
        .limit_uni_next    (uni_limit_next),
        .res               (stream_res)
    );

    // Pick the result for the word's operation.
    always_comb
    begin
        case (mode_reg)
            qrct_pkg::MODE_ARRIVAL, qrct_pkg::MODE_POLL:
            begin
                res_next = data_res;
            end
            qrct_pkg::MODE_STREAM:
            begin
                res_next = stream_res;
            end
            default:
            begin
                res_next.accepted     = 1'b1;
                res_next.update_valid = 1'b0;
                res_next.update_kind  = qrct_pkg::KIND_DATA;
                res_next.update_limit = '0;
            end
        endcase
    end

    // Credit state and settings; configuration writes only while idle (the user's job).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_thresh_reg   <= qrct_pkg::DATA_GROW_THRESH_RST;
            data_amount_reg   <= qrct_pkg::DATA_GROW_AMOUNT_RST;
            stream_thresh_reg <= qrct_pkg::STREAM_GROW_THRESH_RST;
            stream_amount_reg <= qrct_pkg::STREAM_GROW_AMOUNT_RST;
            total_reg         <= '0;
            data_limit_reg    <= '0;
            bidi_limit_reg    <= '0;
            uni_limit_reg     <= '0;
            highest_bidi_reg  <= '0;
            highest_uni_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (qrct_pkg::cfg_index_t'(cfg_index))
                qrct_pkg::CFG_INIT_DATA_LIMIT:    data_limit_reg    <= cfg_data;
                qrct_pkg::CFG_INIT_BIDI_LIMIT:    bidi_limit_reg    <= cfg_data;
                qrct_pkg::CFG_INIT_UNI_LIMIT:     uni_limit_reg     <= cfg_data;
                qrct_pkg::CFG_DATA_GROW_THRESH:   data_thresh_reg   <= cfg_data;
                qrct_pkg::CFG_DATA_GROW_AMOUNT:   data_amount_reg   <= cfg_data;
                qrct_pkg::CFG_STREAM_GROW_THRESH: stream_thresh_reg <= cfg_data;
                qrct_pkg::CFG_STREAM_GROW_AMOUNT: stream_amount_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else if (fire)
        begin
            case (mode_reg)
                qrct_pkg::MODE_ARRIVAL:
                begin
                    total_reg <= total_next;
                end
                qrct_pkg::MODE_POLL:
                begin
                    data_limit_reg <= data_limit_next;
                end
                qrct_pkg::MODE_STREAM:
                begin
                    highest_bidi_reg <= highest_bidi_next;
                    highest_uni_reg  <= highest_uni_next;
                    bidi_limit_reg   <= bidi_limit_next;
                    uni_limit_reg    <= uni_limit_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = res_reg.accepted;
    assign update_valid = res_reg.update_valid;
    assign update_kind  = res_reg.update_kind;
    assign update_limit = res_reg.update_limit;

endmodule

`default_nettype wire
